@@ design/imu_afp_pkg.sv @@
// Package for the IMU angle frame parser: frame constants, the yaw
// transaction type passed between the parser and the top level, and the
// degree conversion. No dependencies.
package imu_afp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned COUNT_W = 4;

    localparam logic [BYTE_W-1:0]  FRAME_HEADER = 8'h55;
    localparam logic [BYTE_W-1:0]  ANGLE_TYPE   = 8'h53;
    localparam logic [COUNT_W-1:0] POS_TYPE     = 4'd1;
    localparam logic [COUNT_W-1:0] POS_YAW_LOW  = 4'd6;
    localparam logic [COUNT_W-1:0] POS_YAW_HIGH = 4'd7;
    localparam logic [COUNT_W-1:0] POS_LAST     = 4'd10;

    // Largest degree value: 65535 * 45 / 64, truncated
    localparam logic [ANGLE_W-1:0] DEG_MAX      = 16'd46079;

    // Completed angle frame: absolute yaw and yaw relative to the zero offset
    typedef struct packed {
        logic [ANGLE_W-1:0] rel;
        logic [ANGLE_W-1:0] yaw;
    } t_yaw_evt;

    // Binary angle to degrees in Q.7: (a * 45) >> 6, built from shifts and adds
    function automatic logic [ANGLE_W-1:0] to_deg_q7(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W+5:0] ext;
        logic [ANGLE_W+5:0] prod;
        ext  = (ANGLE_W+6)'(a);
        prod = (ext << 5) + (ext << 3) + (ext << 2) + ext;
        return prod[ANGLE_W+5:6];
    endfunction

endpackage

@@ design/imu_afp_parser.sv @@
// Frame parser: counts the 11 bytes of a frame, keeps type and yaw bytes,
// and registers one yaw transaction per closed frame of the angle type.
// Depends on imu_afp_pkg.
module imu_afp_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_byte_valid,
    output logic                       o_byte_ready,
    input  logic [7:0]                 i_byte,
    input  logic [15:0]                i_zero_offset,
    output logic                       o_evt_valid,
    input  logic                       i_evt_ready,
    output imu_afp_pkg::t_yaw_evt      o_evt
);
    import imu_afp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FRAME = 2'b10
    } t_parse_state;

    t_parse_state        r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0]   r_type, r_yaw_low, r_yaw_high;
    logic                r_evt_valid;
    t_yaw_evt            r_evt;
    logic                accept;
    logic                emit;
    logic [ANGLE_W-1:0]  yaw;

    assign o_byte_ready = !r_evt_valid || i_evt_ready;
    assign accept       = i_byte_valid && o_byte_ready;
    assign yaw          = {r_yaw_high, r_yaw_low};

    // Frame sequencing: header opens, eleventh byte closes
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_byte == FRAME_HEADER) begin
                    n_state = ST_FRAME;
                    n_count = POS_TYPE;
                end
            end
            ST_FRAME: begin
                if (r_count == POS_LAST) begin
                    n_state = ST_IDLE;
                    n_count = '0;
                    emit    = (r_type == ANGLE_TYPE);
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_count = '0;
            end
        endcase
    end

    // Advance state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Capture type and yaw bytes at their positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type     <= '0;
            r_yaw_low  <= '0;
            r_yaw_high <= '0;
        end else if (accept && r_state == ST_FRAME) begin
            case (r_count)
                POS_TYPE:     r_type     <= i_byte;
                POS_YAW_LOW:  r_yaw_low  <= i_byte;
                POS_YAW_HIGH: r_yaw_high <= i_byte;
                default:      ;
            endcase
        end
    end

    // Hold the yaw transaction until the next stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_valid <= 1'b0;
        end else if (accept && emit) begin
            r_evt_valid <= 1'b1;
        end else if (i_evt_ready) begin
            r_evt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_evt.yaw <= yaw;
            r_evt.rel <= yaw - i_zero_offset;
        end
    end

    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= POS_LAST)
        else $error("byte count past frame end");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_count == '0))
        else $error("byte count nonzero while idle");

    a_evt_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_evt_valid) |-> $past(accept && r_state == ST_FRAME && r_count == POS_LAST))
        else $error("yaw transaction without a closing byte");

endmodule

@@ design/imu_angle_frame_parser_top.sv @@
// Top level of the IMU angle frame parser: zero offset register, parser
// stage and degree conversion into the output register.
// Depends on imu_afp_pkg and imu_afp_parser.
//
//  Channel   | Ports                 | Payload (low bit first)
//  ----------+-----------------------+---------------------------------------
//  input     | s_axis_t*             | rx_byte[7:0]
//  output    | m_axis_t*             | yaw_angle, yaw_degrees, rel_angle,
//            |                       | rel_degrees (16 bit each)
//  config    | i_cfg_wr_en/_wr_data  | zero_offset[15:0]
//
// One byte is accepted per cycle while s_axis_tready is high. A result
// appears on m_axis after the eleventh byte of an angle frame has passed
// through the parser register and then the conversion register. Reset
// (synchronous, active low) returns to waiting for a header and clears the offset to zero.
// A stalled output holds its result; the two registers absorb one more
// transaction before s_axis_tready drops.
module imu_angle_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // yaw_angle[15:0], yaw_degrees[31:16],
                                        // rel_angle[47:32], rel_degrees[63:48]
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data   // zero_offset[15:0]
);
    import imu_afp_pkg::*;

    logic [ANGLE_W-1:0] r_zero_offset;
    logic               evt_valid;
    logic               evt_ready;
    t_yaw_evt           evt;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    // Zero offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
        end else if (i_cfg_wr_en) begin
            r_zero_offset <= i_cfg_wr_data;
        end
    end

    imu_afp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_axis_tvalid),
        .o_byte_ready  (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_zero_offset (r_zero_offset),
        .o_evt_valid   (evt_valid),
        .i_evt_ready   (evt_ready),
        .o_evt         (evt)
    );

    assign evt_ready = !r_out_valid || m_axis_tready;

    // Output register: advance when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (evt_ready) begin
            r_out_valid <= evt_valid;
        end
    end

    // Convert both angles to degrees on the way in
    always_ff @(posedge i_clk) begin
        if (evt_ready && evt_valid) begin
            r_out_data <= {to_deg_q7(evt.rel), evt.rel, to_deg_q7(evt.yaw), evt.yaw};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(evt_valid))
        else $error("output transaction without a parser transaction");

    a_yaw_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[31:16] <= DEG_MAX))
        else $error("absolute degrees out of range");

    a_rel_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[63:48] <= DEG_MAX))
        else $error("relative degrees out of range");

endmodule

@@ bench/tb_imu_angle_frame_parser_top.sv @@
// Self-checking testbench for imu_angle_frame_parser_top: drives serial bytes on s_axis,
// predicts the yaw transactions with its own frame parser and scores m_axis against them.
// Depends on imu_afp_pkg and the design sources.
module tb_imu_angle_frame_parser_top;
    import imu_afp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned MAX_REPORTS = 10;

    // Result transaction, yaw_angle (the last field) in the low bits
    typedef struct packed {
        logic [15:0] rel_degrees;
        logic [15:0] rel_angle;
        logic [15:0] yaw_degrees;
        logic [15:0] yaw_angle;
    } t_yaw_result;

    // Frame parser prediction and queue of yaw transactions still owed by the block
    class t_yaw_scoreboard;
        logic [15:0] zero_ofs;
        bit          in_frame;
        logic [3:0]  byte_pos;
        logic [7:0]  ftype;
        logic [7:0]  yaw_lo;
        logic [7:0]  yaw_hi;
        t_yaw_result owed[$];
        int unsigned n_err;

        function new();
            zero_ofs = '0;
            in_frame = 1'b0;
            byte_pos = '0;
            ftype    = '0;
            yaw_lo   = '0;
            yaw_hi   = '0;
            n_err    = 0;
        endfunction

        function logic [15:0] q7_degrees(input logic [15:0] a);
            logic [21:0] prod;
            prod = 22'(a) * 22'd45;
            return prod[21:6];
        endfunction

        // Track one accepted byte; returns 1 when the byte belongs to a frame
        function bit note_byte(input logic [7:0] b);
            t_yaw_result exp_res;
            logic [15:0] yaw;
            if (!in_frame) begin
                if (b != FRAME_HEADER)
                    return 1'b0;
                in_frame = 1'b1;
                byte_pos = '0;
            end
            if (byte_pos == POS_TYPE)
                ftype = b;
            else if (byte_pos == POS_YAW_LOW)
                yaw_lo = b;
            else if (byte_pos == POS_YAW_HIGH)
                yaw_hi = b;
            if (byte_pos != POS_LAST) begin
                byte_pos = byte_pos + 4'd1;
                return 1'b1;
            end
            // Close the frame; only angle frames produce a transaction
            in_frame = 1'b0;
            byte_pos = '0;
            if (ftype == ANGLE_TYPE) begin
                yaw                 = {yaw_hi, yaw_lo};
                exp_res.yaw_angle   = yaw;
                exp_res.yaw_degrees = q7_degrees(yaw);
                exp_res.rel_angle   = yaw - zero_ofs;
                exp_res.rel_degrees = q7_degrees(exp_res.rel_angle);
                owed.push_back(exp_res);
            end
            return 1'b1;
        endfunction

        function void check_result(input t_yaw_result got);
            t_yaw_result exp_res;
            string       names [4];
            bit          bad;
            names = '{"yaw_angle", "yaw_degrees", "rel_angle", "rel_degrees"};
            if (owed.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected yaw transaction %h", got);
                return;
            end
            exp_res = owed.pop_front();
            bad     = 1'b0;
            for (int f = 0; f < 4; f++) begin
                if (got[16*f +: 16] !== exp_res[16*f +: 16]) begin
                    if (!bad && n_err < MAX_REPORTS)
                        $display("yaw transaction mismatch at %0t:", $realtime);
                    if (n_err < MAX_REPORTS)
                        $display("  %s expected %0d got %0d", names[f],
                                 exp_res[16*f +: 16], got[16*f +: 16]);
                    bad = 1'b1;
                end
            end
            if (bad)
                n_err++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // rx_byte[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;     // yaw_angle, yaw_degrees, rel_angle, rel_degrees
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;    // zero_offset[15:0]

    t_yaw_scoreboard sb;
    int unsigned     fed_count;
    int unsigned     cycle_cnt;
    int unsigned     hold_cycles;
    bit              idle_en;
    bit              tx_quiet;

    imu_angle_frame_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Output backpressure: random stall bursts, plus one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles - 1) @(negedge i_clk);
                hold_cycles = 0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Score every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Offer one byte and hold it until accepted; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (idle_en && !tx_quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (sb.note_byte(b))
            fed_count++;
        @(negedge i_clk);
    endtask

    // Send a frame of len bytes; payload is all headers or random with some headers mixed in
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] yaw,
                              input int len, input bit hdr_fill);
        logic [7:0] b;
        tx_quiet = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                b = FRAME_HEADER;
            else if (i == POS_TYPE)
                b = ftype;
            else if (i == POS_YAW_LOW)
                b = yaw[7:0];
            else if (i == POS_YAW_HIGH)
                b = yaw[15:8];
            else if (hdr_fill || $urandom_range(0, 7) == 0)
                b = FRAME_HEADER;
            else
                b = 8'($urandom());
            send_byte(b);
        end
    endtask

    // Mostly well-formed angle frames; some other types, truncated frames and line noise
    task automatic send_random_frame();
        logic [7:0]  ftype;
        logic [15:0] yaw;
        int          len;
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
        ftype = ($urandom_range(0, 3) != 0) ? ANGLE_TYPE : 8'($urandom());
        case ($urandom_range(0, 9))
            0:       yaw = 16'h0000;
            1:       yaw = 16'hFFFF;
            2:       yaw = sb.zero_ofs;
            3:       yaw = sb.zero_ofs - 16'd1;
            default: yaw = 16'($urandom());
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 10) : POS_LAST + 1;
        send_frame(ftype, yaw, len, 1'b0);
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned start;
        start = fed_count;
        while (fed_count - start < target)
            send_random_frame();
    endtask

    // Write the zero offset once the output side has drained
    task automatic write_offset(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.zero_ofs = v;
    endtask

    // Main sequence
    initial begin
        logic [15:0] offsets [6];
        sb            = new();
        fed_count     = 0;
        hold_cycles   = 0;
        idle_en       = 1'b1;
        tx_quiet      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        offsets = '{16'h0001, 16'hFFFF, 16'h0000, 16'h8000,
                    16'($urandom()), 16'($urandom())};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset offset of zero
        run_random(70);

        for (int p = 0; p < 6; p++) begin
            write_offset(offsets[p]);
            if (p == 0) begin
                // Idle noise, then a zero yaw below the offset with header bytes as payload,
                // then a frame whose type is the header value
                send_byte(8'h00);
                send_byte(8'hFF);
                send_frame(ANGLE_TYPE, 16'h0000, POS_LAST + 1, 1'b1);
                send_frame(FRAME_HEADER, 16'hFFFF, POS_LAST + 1, 1'b0);
            end
            if (p == 1)
                hold_cycles = 400;
            if (p == 5)
                idle_en = 1'b0;
            run_random(80);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any extra transaction
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.n_err == 0 && sb.owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ imu_angle_frame_parser_top.f @@
design/imu_afp_pkg.sv
design/imu_afp_parser.sv
design/imu_angle_frame_parser_top.sv
bench/tb_imu_angle_frame_parser_top.sv
